/* rtl/bal_pkg.sv */
// Package with the shared constants, command and status codes, and controller states.
package bal_pkg;

    // List capacity and derived widths.
    localparam int DEPTH     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 3;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_FIELDS_W = CMD_W + POS_W + DATA_W;
    localparam int M_FIELDS_W = STATUS_W + DATA_W + POS_W + CNT_W + 2;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Command codes carried by an input item.
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_EDIT   = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_GET    = 3'd4,
        CMD_FIND   = 3'd5
    } cmd_t;

    // Status codes carried by a result item.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_BAD_POS   = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_FIXUP,
        S_GET_WAIT,
        S_SCAN,
        S_RESULT
    } state_t;

endpackage

/* rtl/bounded_array_list_engine.sv */
// Fixed-capacity ordered list of signed words held in one synchronous memory.
// Insert and delete shift the entries behind the position one place over through the shift,
// drain and (insert only) fixup states; insert at the end and delete of the last entry shift
// nothing. Find compares the entries in order from the front until a match or the last entry.
// One item at a time: the next is taken while the result is offered.
// Reset clears the count and the handshakes; the entry memory is not cleared.
module bounded_array_list_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: cmd[2:0], position[8:3], data_in[40:9], zero padding.
    input  logic [bal_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: status[2:0], read_value[34:3], found_position[40:35],
    // item_count[47:41], is_empty[48], is_full[49], zero padding.
    output logic [bal_pkg::M_TDATA_W-1:0]     m_tdata
);
    import bal_pkg::*;

    // Entry memory, one write and one registered read per cycle.
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [DATA_W-1:0] mem_wd;

    // Control and working registers.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  src_reg, src_next;
    logic [ADDR_W-1:0]  dst_reg, dst_next;
    logic [ADDR_W-1:0]  last_reg, last_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0]  data_reg, data_next;
    logic               up_reg, up_next;
    logic               pend_reg, pend_next;
    logic               issued_all_reg, issued_all_next;
    status_t            res_status_reg, res_status_next;
    logic [DATA_W-1:0]  res_read_reg, res_read_next;
    logic [POS_W-1:0]   res_fpos_reg, res_fpos_next;
    logic               m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Input item fields.
    cmd_t               s_cmd;
    logic [POS_W-1:0]   s_pos;
    logic [DATA_W-1:0]  s_data;

    assign s_cmd  = cmd_t'(s_tdata[CMD_W-1:0]);
    assign s_pos  = s_tdata[CMD_W+POS_W-1:CMD_W];
    assign s_data = s_tdata[CMD_W+POS_W+DATA_W-1:CMD_W+POS_W];

    // Checks against the count as it stands when the item arrives.
    logic is_full, is_empty, pos_lt, pos_le, pos_eq, pos_last, accept, out_free, match;
    logic [CNT_W-1:0] pos_ext, count_dec;

    assign pos_ext   = CNT_W'(s_pos);
    assign count_dec = count_reg - CNT_W'(1);
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign pos_lt    = (pos_ext < count_reg);
    assign pos_le    = (pos_ext <= count_reg);
    assign pos_eq    = (pos_ext == count_reg);
    assign pos_last  = (pos_ext == count_dec);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign match     = pend_reg && (rd_data == data_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (s_cmd)
                        CMD_INSERT: begin
                            if (!is_full && pos_le && !pos_eq) begin
                                state_next = S_SHIFT;
                            end else begin
                                state_next = S_RESULT;
                            end
                        end
                        CMD_DELETE: begin
                            if (!is_empty && pos_lt && !pos_last) begin
                                state_next = S_SHIFT;
                            end else begin
                                state_next = S_RESULT;
                            end
                        end
                        CMD_GET: begin
                            state_next = pos_lt ? S_GET_WAIT : S_RESULT;
                        end
                        CMD_FIND: begin
                            state_next = is_empty ? S_RESULT : S_SCAN;
                        end
                        default: begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                if (src_reg == last_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = up_reg ? S_FIXUP : S_RESULT;
            end
            S_FIXUP: begin
                state_next = S_RESULT;
            end
            S_GET_WAIT: begin
                state_next = S_RESULT;
            end
            S_SCAN: begin
                if (match || issued_all_reg) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and result fields.
    always_comb begin
        count_next      = count_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        last_next       = last_reg;
        pos_next        = pos_reg;
        data_next       = data_reg;
        up_next         = up_reg;
        pend_next       = pend_reg;
        issued_all_next = issued_all_reg;
        res_status_next = res_status_reg;
        res_read_next   = res_read_reg;
        res_fpos_next   = res_fpos_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        rd_addr         = src_reg;
        mem_we          = 1'b0;
        mem_wa          = dst_reg;
        mem_wd          = rd_data;

        case (state_reg)
            S_IDLE: begin
                // The get read is issued at the item's position right away.
                rd_addr = ADDR_W'(s_pos);
                if (accept) begin
                    res_status_next = ST_OK;
                    res_read_next   = '0;
                    res_fpos_next   = '0;
                    pos_next        = ADDR_W'(s_pos);
                    data_next       = s_data;
                    pend_next       = 1'b0;
                    issued_all_next = 1'b0;
                    case (s_cmd)
                        CMD_APPEND: begin
                            if (is_full) begin
                                res_status_next = ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_wa     = ADDR_W'(count_reg);
                                mem_wd     = s_data;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_INSERT: begin
                            if (is_full) begin
                                res_status_next = ST_FULL;
                            end else if (!pos_le) begin
                                res_status_next = ST_BAD_POS;
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                                if (pos_eq) begin
                                    mem_we = 1'b1;
                                    mem_wa = ADDR_W'(s_pos);
                                    mem_wd = s_data;
                                end
                                src_next  = ADDR_W'(count_dec);
                                last_next = ADDR_W'(s_pos);
                                up_next   = 1'b1;
                            end
                        end
                        CMD_EDIT: begin
                            if (pos_lt) begin
                                mem_we = 1'b1;
                                mem_wa = ADDR_W'(s_pos);
                                mem_wd = s_data;
                            end else begin
                                res_status_next = ST_BAD_POS;
                            end
                        end
                        CMD_DELETE: begin
                            if (is_empty) begin
                                res_status_next = ST_EMPTY;
                            end else if (!pos_lt) begin
                                res_status_next = ST_BAD_POS;
                            end else begin
                                count_next = count_dec;
                                src_next   = ADDR_W'(s_pos) + ADDR_W'(1);
                                last_next  = ADDR_W'(count_dec);
                                up_next    = 1'b0;
                            end
                        end
                        CMD_GET: begin
                            if (!pos_lt) begin
                                res_status_next = ST_BAD_POS;
                                res_read_next   = '1;
                            end
                        end
                        CMD_FIND: begin
                            if (is_empty) begin
                                res_status_next = ST_NOT_FOUND;
                            end else begin
                                src_next  = '0;
                                last_next = ADDR_W'(count_dec);
                            end
                        end
                        default: begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // Write the word read last cycle one place over and read the next one.
                mem_we    = pend_reg;
                pend_next = 1'b1;
                if (up_reg) begin
                    dst_next = src_reg + ADDR_W'(1);
                    src_next = src_reg - ADDR_W'(1);
                end else begin
                    dst_next = src_reg - ADDR_W'(1);
                    src_next = src_reg + ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                mem_we = 1'b1;
            end
            S_FIXUP: begin
                // The inserted word lands in the gap the shift opened.
                mem_we = 1'b1;
                mem_wa = pos_reg;
                mem_wd = data_reg;
            end
            S_GET_WAIT: begin
                res_read_next = rd_data;
            end
            S_SCAN: begin
                // Compare the word read last cycle while the next read is issued.
                if (match) begin
                    res_fpos_next = POS_W'(dst_reg);
                end else if (issued_all_reg) begin
                    res_status_next = ST_NOT_FOUND;
                end else begin
                    dst_next        = src_reg;
                    pend_next       = 1'b1;
                    issued_all_next = (src_reg == last_reg);
                    src_next        = src_reg + ADDR_W'(1);
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({
                        is_full, is_empty, count_reg, res_fpos_reg, res_read_reg,
                        res_status_reg});
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Entry memory.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data <= mem[rd_addr];
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        last_reg       <= last_next;
        pos_reg        <= pos_next;
        data_reg       <= data_next;
        up_reg         <= up_next;
        pend_reg       <= pend_next;
        issued_all_reg <= issued_all_next;
        res_status_reg <= res_status_next;
        res_read_reg   <= res_read_next;
        res_fpos_reg   <= res_fpos_next;
        m_data_reg     <= m_data_next;
    end

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // Get and find never modify the memory.
    a_read_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GET_WAIT || state_reg == S_SCAN) |-> !mem_we)
        else $error("memory written during a read-only command");

    // The count only changes when an item is accepted.
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(count_reg))
        else $error("entry count changed without an accepted item");

    // During a shift the entry written is never the one being read.
    a_shift_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && pend_reg) |-> (dst_reg != src_reg))
        else $error("shift writes the entry it reads");

endmodule

/* tb/tb_bounded_array_list_engine.sv */
// Self-checking testbench for the bounded array list engine.
module tb_bounded_array_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import bal_pkg::*;

    // One result item as the list should report it.
    typedef struct {
        status_t             status;
        logic [DATA_W-1:0]   read_value;
        logic [POS_W-1:0]    found_pos;
        logic [CNT_W-1:0]    count;
        logic                empty;
        logic                full;
    } list_reply_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // Fields from bit 0: cmd[2:0], position[8:3], data_in[40:9], zero padding.
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // Fields from bit 0: status[2:0], read_value[34:3], found_position[40:35],
    // item_count[47:41], is_empty[48], is_full[49], zero padding.
    logic [M_TDATA_W-1:0]  m_tdata;

    // Shadow copy of the list contents and length.
    logic [DATA_W-1:0]     shadow_words [DEPTH];
    int                    shadow_len = 0;
    list_reply_t           pending_replies [$];
    int                    mismatches = 0;
    bit                    idling_on  = 1'b1;
    int                    stall_left = 0;
    int                    fill_goal  = DEPTH / 2;

    bounded_array_list_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Apply one command to the shadow list and queue the reply it should produce.
    task automatic track_list_command(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                                      input logic [DATA_W-1:0] word);
        list_reply_t r;
        int i;
        int p;
        p = int'(pos);
        r.status     = ST_OK;
        r.read_value = '0;
        r.found_pos  = '0;
        case (op)
            CMD_APPEND: begin
                if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_words[shadow_len] = word;
                    shadow_len++;
                end
            end
            CMD_INSERT: begin
                // The full check wins over the position check.
                if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (p > shadow_len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (i = shadow_len; i > p; i--) shadow_words[i] = shadow_words[i - 1];
                    shadow_words[p] = word;
                    shadow_len++;
                end
            end
            CMD_EDIT: begin
                if (p < shadow_len) begin
                    shadow_words[p] = word;
                end else begin
                    r.status = ST_BAD_POS;
                end
            end
            CMD_DELETE: begin
                // The empty check wins over the position check.
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (p >= shadow_len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (i = p; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i + 1];
                    shadow_len--;
                end
            end
            CMD_GET: begin
                if (p < shadow_len) begin
                    r.read_value = shadow_words[p];
                end else begin
                    r.read_value = '1;
                    r.status     = ST_BAD_POS;
                end
            end
            CMD_FIND: begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < shadow_len; i++) begin
                    if (shadow_words[i] == word) begin
                        r.found_pos = POS_W'(i);
                        r.status    = ST_OK;
                        break;
                    end
                end
            end
            default: begin
                // Unused codes leave the list alone and report OK with the count and flags.
            end
        endcase
        r.count = CNT_W'(shadow_len);
        r.empty = (shadow_len == 0);
        r.full  = (shadow_len == DEPTH);
        pending_replies.push_back(r);
    endtask

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endfunction

    // Compare every accepted result item with the oldest expected reply.
    always @(posedge aclk) begin
        list_reply_t         want;
        logic [STATUS_W-1:0] got_status;
        logic [DATA_W-1:0]   got_read;
        logic [POS_W-1:0]    got_found;
        logic [CNT_W-1:0]    got_count;
        logic                got_empty;
        logic                got_full;
        if (aresetn && m_tvalid && m_tready) begin
            got_status = m_tdata[2:0];
            got_read   = m_tdata[34:3];
            got_found  = m_tdata[40:35];
            got_count  = m_tdata[47:41];
            got_empty  = m_tdata[48];
            got_full   = m_tdata[49];
            if (pending_replies.size() == 0) begin
                note_failure($sformatf("result item with no command waiting: %h", m_tdata));
            end else begin
                want = pending_replies.pop_front();
                if (got_status !== want.status || got_read !== want.read_value ||
                    got_found !== want.found_pos || got_count !== want.count ||
                    got_empty !== want.empty || got_full !== want.full) begin
                    note_failure($sformatf({"reply mismatch: expected status %0d read %h ",
                        "found %0d count %0d empty %b full %b; got status %0d read %h ",
                        "found %0d count %0d empty %b full %b"},
                        want.status, want.read_value, want.found_pos, want.count,
                        want.empty, want.full, got_status, got_read, got_found,
                        got_count, got_empty, got_full));
                end
            end
        end
    end

    // Receiver back-pressure in random bursts while idling is on.
    always @(negedge aclk) begin
        if (!idling_on) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Present one command item, with an optional gap first, and wait for it to be taken.
    task automatic send_item(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] word);
        @(negedge aclk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, word, pos, op};
        do @(posedge aclk); while (!s_tready);
        track_list_command(op, pos, word);
    endtask

    // Stop sending and hold off until every outstanding reply has come back.
    task automatic wait_all_replies();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    // Random command shaped by the current fill goal, so the list sweeps from empty to full.
    task automatic send_random_item();
        logic [CMD_W-1:0]  op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] word;
        int roll;
        int lim;
        bit grow;
        grow = (shadow_len < fill_goal);
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            op = CMD_W'($urandom_range(6, 7));
        end else begin
            roll = $urandom_range(0, 99);
            if (grow) begin
                if (roll < 40)      op = CMD_APPEND;
                else if (roll < 60) op = CMD_INSERT;
                else if (roll < 68) op = CMD_DELETE;
                else if (roll < 78) op = CMD_EDIT;
                else if (roll < 89) op = CMD_GET;
                else                op = CMD_FIND;
            end else begin
                if (roll < 8)       op = CMD_APPEND;
                else if (roll < 16) op = CMD_INSERT;
                else if (roll < 55) op = CMD_DELETE;
                else if (roll < 68) op = CMD_EDIT;
                else if (roll < 84) op = CMD_GET;
                else                op = CMD_FIND;
            end
        end

        // Small values give duplicates for find; corners and full-range words fill the rest.
        roll = $urandom_range(0, 9);
        if (op == CMD_FIND && shadow_len > 0 && roll < 5) begin
            word = shadow_words[$urandom_range(0, shadow_len - 1)];
        end else if (roll < 4) begin
            word = DATA_W'($urandom_range(0, 15));
        end else if (roll == 4) begin
            case ($urandom_range(0, 3))
                0:       word = 32'h7FFF_FFFF;
                1:       word = 32'h8000_0000;
                2:       word = '1;
                default: word = '0;
            endcase
        end else begin
            word = $urandom();
        end

        // Mostly legal positions, with some drawn from the whole field.
        lim = (op == CMD_INSERT) ? shadow_len : shadow_len - 1;
        if (lim > DEPTH - 1) lim = DEPTH - 1;
        if (lim < 0 || $urandom_range(0, 4) == 0) begin
            pos = POS_W'($urandom_range(0, 63));
        end else begin
            pos = POS_W'($urandom_range(0, lim));
        end
        send_item(op, pos, word);
    endtask

    // Every operation and every error case but a full list, on a short list.
    task automatic test_directed();
        send_item(CMD_DELETE, 6'd0, 32'd0);
        send_item(CMD_GET, 6'd0, 32'd0);
        send_item(CMD_FIND, 6'd0, 32'd5);
        send_item(CMD_EDIT, 6'd0, 32'd1);
        send_item(CMD_INSERT, 6'd1, 32'd2);
        send_item(CMD_INSERT, 6'd0, 32'h7FFF_FFFF);
        send_item(CMD_APPEND, 6'd63, 32'h8000_0000);
        send_item(CMD_APPEND, 6'd0, 32'h0000_0000);
        send_item(CMD_INSERT, 6'd1, 32'hFFFF_FFFF);
        send_item(CMD_INSERT, 6'd4, 32'h1234_5678);
        send_item(CMD_INSERT, 6'd63, 32'd9);
        send_item(CMD_EDIT, 6'd2, 32'h5555_5555);
        send_item(CMD_EDIT, 6'd63, 32'd3);
        send_item(CMD_GET, 6'd0, 32'd0);
        send_item(CMD_GET, 6'd4, 32'hFFFF_FFFF);
        send_item(CMD_GET, 6'd5, 32'd0);
        send_item(CMD_FIND, 6'd63, 32'h8000_0000);
        send_item(CMD_FIND, 6'd0, 32'hAAAA_AAAA);
        send_item(CMD_W'(6), 6'd21, 32'h0F0F_0F0F);
        send_item(CMD_W'(7), 6'd63, 32'hFFFF_FFFF);
        send_item(CMD_DELETE, 6'd63, 32'd0);
        send_item(CMD_DELETE, 6'd4, 32'd0);
        send_item(CMD_DELETE, 6'd0, 32'd0);
        send_item(CMD_APPEND, 6'd0, 32'h5555_5555);
        send_item(CMD_FIND, 6'd0, 32'h5555_5555);
    endtask

    // Fill to capacity, exercise the full-list cases and the longest shifts, then drain.
    task automatic test_full_list();
        while (shadow_len < DEPTH) send_item(CMD_APPEND, 6'd0, $urandom());
        send_item(CMD_APPEND, 6'd0, 32'd7);
        send_item(CMD_INSERT, 6'd0, 32'd7);
        send_item(CMD_INSERT, 6'd63, 32'd7);
        send_item(CMD_EDIT, 6'd63, 32'h8000_0000);
        send_item(CMD_GET, 6'd63, 32'd0);
        send_item(CMD_FIND, 6'd0, shadow_words[63]);
        send_item(CMD_FIND, 6'd0, shadow_words[0]);
        send_item(CMD_DELETE, 6'd63, 32'd0);
        send_item(CMD_INSERT, 6'd0, 32'h7FFF_FFFF);
        send_item(CMD_DELETE, 6'd0, 32'd0);
        send_item(CMD_INSERT, 6'd0, 32'hFFFF_FFFF);
        send_item(CMD_GET, 6'd62, 32'd0);
        while (shadow_len > 0) begin
            send_item(CMD_DELETE, POS_W'($urandom_range(0, shadow_len - 1)), 32'd0);
        end
        send_item(CMD_DELETE, 6'd63, 32'd0);
    endtask

    // Long random mix; the fill goal moves, idling switches on and off, and the sender pauses.
    task automatic test_random_mix(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(0, 3))
                    0:       fill_goal = 0;
                    1:       fill_goal = DEPTH;
                    default: fill_goal = $urandom_range(1, DEPTH - 1);
                endcase
            end
            if (k % 50 == 0) idling_on = ($urandom_range(0, 3) != 0);
            if (k % 200 == 199) wait_all_replies();
            send_random_item();
        end
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_streaming(input int n);
        int k;
        idling_on = 1'b0;
        fill_goal = DEPTH;
        for (k = 0; k < n; k++) begin
            if (k == n / 2) fill_goal = 0;
            send_random_item();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        wait_all_replies();
        test_full_list();
        wait_all_replies();
        test_random_mix(850);
        wait_all_replies();
        test_streaming(150);

        wait_all_replies();
        repeat (80) @(posedge aclk);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/bal_pkg.sv
rtl/bounded_array_list_engine.sv
tb/tb_bounded_array_list_engine.sv
